>>> rtl/msb_pkg.sv
// shared types, sizes and codes for the multi-stack shared buffer
// used by msb_engine and multi_stack_shared_buffer; no dependencies
`default_nettype none

package msb_pkg;

    // sizes of the block
    localparam int NUM_STACKS = 8;
    localparam int NUM_SLOTS  = 64;
    localparam int DATA_W     = 32;

    // fixed field widths
    localparam int STACK_ID_W = 3;
    localparam int ITEM_W     = 32;

    // derived widths
    localparam int STK_IDX_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int LINK_W     = $clog2(NUM_SLOTS + 1);

    // null link marker
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

    // largest positive stored value, cut to the item width
    localparam logic [DATA_W-1:0] DATA_MAX     = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [ITEM_W-1:0] DATA_MAX_OUT = ITEM_W'(DATA_MAX);

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        req_kind_t                      req_type;
        logic [STACK_ID_W-1:0]          stack_id;
        logic signed [ITEM_W-1:0]       push_value;
    } req_t;

    typedef struct packed {
        logic signed [ITEM_W-1:0]       pop_value;
        status_t                        status;
        logic                           store_full;
        logic                           stack_empty;
    } rsp_t;

    function automatic logic is_null(input logic [LINK_W-1:0] link);
        return link >= NULL_LINK;
    endfunction

endpackage

`default_nettype wire

>>> rtl/multi_stack_shared_buffer.sv
// top level of the multi-stack shared buffer: stream ports and result register
// depends on msb_pkg and msb_engine
//
// eight lifo stacks share a store of 64 slots chained by a free list
// input channel s_*: one push or pop request per transaction
//   s_tuser selects the operation and the stack, s_tdata carries the pushed item
// result channel m_*: exactly one result transaction per request, in order
//   m_tdata is the popped item (largest positive value on underflow, 0 for a push)
//   m_tuser gives status (ok, overflow, underflow), store full and stack empty
// requests do not overlap: a new one is taken only in the idle state, once the
//   last has written back; the idle state reads the link of the free head or stack top
//   slot, the exec state writes the relinked slot, the free head and the stack top back
// a finished result waits in the output register; a new request is taken
//   meanwhile and holds in its writeback cycle until the register frees up
// reset: every stack empty, all slots free in index order; link written flags
//   stand in for the initial chain, so no clearing pass is needed
`default_nettype none

module multi_stack_shared_buffer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] push_value
    input  wire logic [3:0]  s_tuser,   // [0] req_type, [3:1] stack_id
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] pop_value
    output logic [3:0]       m_tuser    // [1:0] status, [2] store_full, [3] stack_empty
);

    msb_pkg::req_t req;
    msb_pkg::rsp_t rsp;
    msb_pkg::rsp_t rsp_reg;

    logic rsp_valid;
    logic out_free;
    logic m_tvalid_reg, m_tvalid_next;

    // unpack the request transaction
    assign req.req_type   = msb_pkg::req_kind_t'(s_tuser[0]);
    assign req.stack_id   = s_tuser[3:1];
    assign req.push_value = s_tdata;

    // output register can take a result when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;

    msb_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_ready (out_free),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // result valid flag
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (rsp_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded only when the engine commits
    always_ff @(posedge aclk) begin
        if (rsp_valid) begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = rsp_reg.pop_value;
    assign m_tuser  = {rsp_reg.stack_empty, rsp_reg.store_full, rsp_reg.status};

endmodule

`default_nettype wire

>>> rtl/msb_engine.sv
// request sequencer with the slot data and link memories, free head and stack tops
// depends on msb_pkg
`default_nettype none

module msb_engine (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire msb_pkg::req_t req,
    input  wire logic          rsp_ready,
    output logic               rsp_valid,
    output msb_pkg::rsp_t      rsp
);

    // memories
    logic [msb_pkg::DATA_W-1:0] data_mem [msb_pkg::NUM_SLOTS];
    logic [msb_pkg::LINK_W-1:0] link_mem [msb_pkg::NUM_SLOTS];

    // link written flags; an unwritten link reads as its reset chain value
    logic [msb_pkg::NUM_SLOTS-1:0] link_vld_reg;

    logic [msb_pkg::LINK_W-1:0] stack_top_reg [msb_pkg::NUM_STACKS];
    logic [msb_pkg::LINK_W-1:0] free_head_reg, free_head_next;

    msb_pkg::state_t state_reg, state_next;

    // per-request registers
    msb_pkg::req_t                  req_reg;
    logic [msb_pkg::STK_IDX_W-1:0]  sel_reg;
    logic                           id_ok_reg;
    logic                           fail_reg;
    logic [msb_pkg::LINK_W-1:0]     top_cur_reg;
    logic [msb_pkg::SLOT_IDX_W-1:0] idx_reg;
    logic [msb_pkg::LINK_W-1:0]     link_rd_reg;
    logic [msb_pkg::DATA_W-1:0]     data_rd_reg;

    logic                           accept;
    logic                           id_ok_in;
    logic [msb_pkg::STK_IDX_W-1:0]  sel_in;
    logic [msb_pkg::LINK_W-1:0]     top_in;
    logic [msb_pkg::LINK_W-1:0]     src_in;
    logic [msb_pkg::SLOT_IDX_W-1:0] idx_in;

    logic                           commit;
    logic                           do_write;
    logic                           is_push;
    logic [msb_pkg::LINK_W-1:0]     link_raw;
    logic [msb_pkg::LINK_W-1:0]     link_val;
    logic [msb_pkg::LINK_W-1:0]     link_wdata;
    logic [msb_pkg::LINK_W-1:0]     free_new;
    logic [msb_pkg::LINK_W-1:0]     top_new;

    // request side
    assign accept   = req_valid && req_ready;
    assign id_ok_in = 32'(req.stack_id) < 32'(msb_pkg::NUM_STACKS);
    assign sel_in   = id_ok_in ? msb_pkg::STK_IDX_W'(req.stack_id) : '0;
    assign top_in   = stack_top_reg[sel_in];
    assign src_in   = (req.req_type == msb_pkg::REQ_PUSH) ? free_head_reg : top_in;
    assign idx_in   = msb_pkg::SLOT_IDX_W'(src_in);

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= msb_pkg::ST_IDLE;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        req_ready  = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            msb_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    state_next = msb_pkg::ST_EXEC;
                end
            end
            msb_pkg::ST_EXEC: begin
                if (rsp_ready) begin
                    commit     = 1'b1;
                    state_next = msb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = msb_pkg::ST_IDLE;
            end
        endcase
    end

    // capture the request and the operand slot
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg     <= req;
            sel_reg     <= sel_in;
            id_ok_reg   <= id_ok_in;
            fail_reg    <= !id_ok_in || msb_pkg::is_null(src_in);
            top_cur_reg <= top_in;
            idx_reg     <= idx_in;
        end
    end

    // writeback computation
    assign is_push  = (req_reg.req_type == msb_pkg::REQ_PUSH);
    assign link_raw = link_vld_reg[idx_reg] ? link_rd_reg
                    : msb_pkg::LINK_W'(idx_reg) + msb_pkg::LINK_W'(1);
    assign link_val = msb_pkg::is_null(link_raw) ? msb_pkg::NULL_LINK : link_raw;
    assign do_write = commit && !fail_reg;

    always_comb begin
        if (is_push) begin
            free_new   = link_val;
            top_new    = msb_pkg::LINK_W'(idx_reg);
            link_wdata = top_cur_reg;
        end else begin
            free_new   = msb_pkg::LINK_W'(idx_reg);
            top_new    = link_val;
            link_wdata = free_head_reg;
        end
        if (fail_reg) begin
            free_new = free_head_reg;
            top_new  = top_cur_reg;
        end
        free_head_next = commit ? free_new : free_head_reg;
    end

    // stack tops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msb_pkg::NUM_STACKS; i++) begin
                stack_top_reg[i] <= msb_pkg::NULL_LINK;
            end
        end else if (do_write) begin
            stack_top_reg[sel_reg] <= top_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (do_write) begin
            link_vld_reg[idx_reg] <= 1'b1;
        end
    end

    // link memory
    always_ff @(posedge aclk) begin
        if (do_write) begin
            link_mem[idx_reg] <= link_wdata;
        end
        if (accept) begin
            link_rd_reg <= link_mem[idx_in];
        end
    end

    // data memory, written by pushes only
    always_ff @(posedge aclk) begin
        if (do_write && is_push) begin
            data_mem[idx_reg] <= msb_pkg::DATA_W'(req_reg.push_value);
        end
        if (accept) begin
            data_rd_reg <= data_mem[idx_in];
        end
    end

    // response
    assign rsp_valid = commit;

    always_comb begin
        rsp.store_full  = msb_pkg::is_null(free_new);
        rsp.stack_empty = !id_ok_reg || msb_pkg::is_null(top_new);
        if (is_push) begin
            rsp.pop_value = '0;
            rsp.status    = fail_reg ? msb_pkg::STATUS_OVERFLOW : msb_pkg::STATUS_OK;
        end else if (fail_reg) begin
            rsp.pop_value = msb_pkg::DATA_MAX_OUT;
            rsp.status    = msb_pkg::STATUS_UNDERFLOW;
        end else begin
            rsp.pop_value = msb_pkg::ITEM_W'(signed'(data_rd_reg));
            rsp.status    = msb_pkg::STATUS_OK;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_multi_stack_shared_buffer.sv
// self-checking testbench for multi_stack_shared_buffer: pushes and pops on eight
// stacks sharing one slot store, each result checked against a local stack model
// depends on msb_pkg and the multi_stack_shared_buffer rtl
`default_nettype none

module tb_multi_stack_shared_buffer;

    timeunit 1ns;
    timeprecision 1ps;

    // run limit in clock cycles, far above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;   // [31:0] push_value
    logic [3:0]            s_tuser  = '0;   // [0] req_type, [3:1] stack_id
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [31:0]           m_tdata;         // [31:0] pop_value
    logic [3:0]            m_tuser;         // [1:0] status, [2] store_full, [3] stack_empty

    // local copy of the shared store: items, links, stack tops and free list head
    logic [msb_pkg::ITEM_W-1:0] item_mem [msb_pkg::NUM_SLOTS];
    logic [msb_pkg::LINK_W-1:0] link_mem [msb_pkg::NUM_SLOTS];
    logic [msb_pkg::LINK_W-1:0] top_of   [msb_pkg::NUM_STACKS];
    logic [msb_pkg::LINK_W-1:0] free_head;

    // results still owed by the block, oldest first
    msb_pkg::rsp_t         pending_results [$];

    int unsigned           mismatches = 0;
    int unsigned           cycle_count = 0;
    // idle percentages: sender gaps and receiver stalls, zero turns them off
    int unsigned           gap_pct   = 0;
    int unsigned           stall_pct = 0;

    multi_stack_shared_buffer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("multi_stack_shared_buffer verification failed");
            $finish;
        end
    end

    // same reset picture as the block: all slots free in index order, every stack empty
    function automatic void clear_store_model();
        for (int i = 0; i < msb_pkg::NUM_SLOTS; i++) begin
            link_mem[i] = msb_pkg::LINK_W'(i + 1);
        end
        link_mem[msb_pkg::NUM_SLOTS-1] = msb_pkg::NULL_LINK;
        for (int s = 0; s < msb_pkg::NUM_STACKS; s++) begin
            top_of[s] = msb_pkg::NULL_LINK;
        end
        free_head = '0;
    endfunction

    // applies one request to the local store and returns the result it must give
    function automatic msb_pkg::rsp_t apply_stack_request(
            input msb_pkg::req_kind_t kind,
            input logic [msb_pkg::STACK_ID_W-1:0] sid,
            input logic [msb_pkg::ITEM_W-1:0] value);
        msb_pkg::rsp_t                  r;
        logic [msb_pkg::SLOT_IDX_W-1:0] slot;
        logic                           id_ok;
        r        = '0;
        r.status = msb_pkg::STATUS_OK;
        id_ok    = int'(sid) < msb_pkg::NUM_STACKS;
        if (kind == msb_pkg::REQ_PUSH) begin
            if (!id_ok || free_head >= msb_pkg::NULL_LINK) begin
                // no free slot: nothing moves
                r.status = msb_pkg::STATUS_OVERFLOW;
            end else begin
                slot           = msb_pkg::SLOT_IDX_W'(free_head);
                free_head      = (link_mem[slot] >= msb_pkg::NULL_LINK) ?
                                 msb_pkg::NULL_LINK : link_mem[slot];
                link_mem[slot] = top_of[sid];
                top_of[sid]    = msb_pkg::LINK_W'(slot);
                item_mem[slot] = value;
            end
        end else begin
            if (!id_ok || top_of[sid] >= msb_pkg::NULL_LINK) begin
                // empty stack: largest positive value comes back
                r.status    = msb_pkg::STATUS_UNDERFLOW;
                r.pop_value = msb_pkg::DATA_MAX_OUT;
            end else begin
                slot           = msb_pkg::SLOT_IDX_W'(top_of[sid]);
                top_of[sid]    = (link_mem[slot] >= msb_pkg::NULL_LINK) ?
                                 msb_pkg::NULL_LINK : link_mem[slot];
                link_mem[slot] = free_head;
                free_head      = msb_pkg::LINK_W'(slot);
                r.pop_value    = item_mem[slot];
            end
        end
        r.store_full  = free_head >= msb_pkg::NULL_LINK;
        r.stack_empty = !id_ok || top_of[sid] >= msb_pkg::NULL_LINK;
        return r;
    endfunction

    // one request transaction; valid stays high into the next call unless a gap is drawn
    task automatic issue_request(input msb_pkg::req_kind_t kind,
                                 input logic [msb_pkg::STACK_ID_W-1:0] sid,
                                 input logic [msb_pkg::ITEM_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= {sid, kind};
        s_tdata  <= value;
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_results.push_back(apply_stack_request(kind, sid, value));
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // receiver back-pressure in random bursts, drawn with stall_pct
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // result checker: every result transaction against the oldest expectation
    always @(posedge aclk) begin
        msb_pkg::rsp_t want;
        msb_pkg::rsp_t got;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.pop_value   = m_tdata;
            got.status      = msb_pkg::status_t'(m_tuser[1:0]);
            got.store_full  = m_tuser[2];
            got.stack_empty = m_tuser[3];
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result value %0d status %0d full %0b empty %0b",
                         $realtime, got.pop_value, got.status, got.store_full,
                         got.stack_empty);
            end else begin
                want = pending_results.pop_front();
                if (got.pop_value !== want.pop_value || got.status !== want.status ||
                    got.store_full !== want.store_full ||
                    got.stack_empty !== want.stack_empty) begin
                    mismatches++;
                    $display("%0t: expected value %0d status %0d full %0b empty %0b, %s",
                             $realtime, want.pop_value, want.status, want.store_full,
                             want.stack_empty, "got");
                    $display("%0t:   actual value %0d status %0d full %0b empty %0b",
                             $realtime, got.pop_value, got.status, got.store_full,
                             got.stack_empty);
                end
            end
        end
    end

    // pops on stacks that were never pushed
    task automatic test_empty_stack_pops();
        issue_request(msb_pkg::REQ_POP, 3'd0, 32'h0);
        issue_request(msb_pkg::REQ_POP, 3'd7, 32'hffff_ffff);
        issue_request(msb_pkg::REQ_POP, 3'd5, 32'h1234_5678);
    endtask

    // extreme items come back in reverse order, then each emptied stack underflows
    task automatic test_value_extremes();
        logic [msb_pkg::ITEM_W-1:0] corner [7];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h1,
                   32'h5555_5555, 32'haaaa_aaaa};
        foreach (corner[i]) begin
            issue_request(msb_pkg::REQ_PUSH, (i < 5) ? 3'd7 : 3'd0, corner[i]);
        end
        // interleave pops across the two stacks
        issue_request(msb_pkg::REQ_POP, 3'd0, 32'h0);
        for (int i = 0; i < 5; i++) begin
            issue_request(msb_pkg::REQ_POP, 3'd7, $urandom);
        end
        issue_request(msb_pkg::REQ_POP, 3'd7, 32'h0);
        issue_request(msb_pkg::REQ_POP, 3'd0, 32'h0);
        issue_request(msb_pkg::REQ_POP, 3'd0, 32'h0);
    endtask

    // fill the whole store, run into overflow, then drain every stack into underflow
    task automatic test_fill_and_drain();
        gap_pct   = 30;
        stall_pct = 30;
        for (int i = 0; i < msb_pkg::NUM_SLOTS + 3; i++) begin
            issue_request(msb_pkg::REQ_PUSH,
                          msb_pkg::STACK_ID_W'($urandom_range(0, msb_pkg::NUM_STACKS - 1)),
                          $urandom);
        end
        // a pop and a push while full keep the free list at its edge
        issue_request(msb_pkg::REQ_POP, 3'd2, 32'h0);
        issue_request(msb_pkg::REQ_PUSH, 3'd6, $urandom);
        issue_request(msb_pkg::REQ_PUSH, 3'd6, $urandom);
        for (int s = 0; s < msb_pkg::NUM_STACKS; s++) begin
            while (top_of[s] < msb_pkg::NULL_LINK) begin
                issue_request(msb_pkg::REQ_POP, msb_pkg::STACK_ID_W'(s), $urandom);
            end
            issue_request(msb_pkg::REQ_POP, msb_pkg::STACK_ID_W'(s), $urandom);
        end
    endtask

    // random traffic in segments: push bias, stack spread and idling vary per segment
    task automatic test_random_traffic(input int unsigned item_total);
        int unsigned                sent;
        int unsigned                seg_len;
        int unsigned                push_pct;
        int unsigned                lo_id;
        int unsigned                hi_id;
        logic [msb_pkg::ITEM_W-1:0] value;
        sent = 0;
        while (sent < item_total) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0: push_pct = 90;
                1: push_pct = 10;
                default: push_pct = 50;
            endcase
            // sometimes hammer one or two stacks, otherwise spread over all
            if ($urandom_range(0, 2) == 0) begin
                lo_id = $urandom_range(0, msb_pkg::NUM_STACKS - 2);
                hi_id = lo_id + $urandom_range(0, 1);
            end else begin
                lo_id = 0;
                hi_id = msb_pkg::NUM_STACKS - 1;
            end
            // last stretch runs with no idling at all
            if (sent + 150 >= item_total) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            end
            for (int i = 0; i < seg_len; i++) begin
                case ($urandom_range(0, 9))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7fff_ffff;
                    default: value = $urandom;
                endcase
                issue_request(($urandom_range(99) < push_pct) ?
                              msb_pkg::REQ_PUSH : msb_pkg::REQ_POP,
                              msb_pkg::STACK_ID_W'($urandom_range(lo_id, hi_id)), value);
            end
            sent += seg_len;
        end
    endtask

    initial begin
        clear_store_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack_pops();
        test_value_extremes();
        test_fill_and_drain();
        test_random_traffic(1000);

        s_tvalid <= 1'b0;
        // drain the result channel, then wait for stray results
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("multi_stack_shared_buffer verification clean");
        end else begin
            $display("multi_stack_shared_buffer verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
